>>> src/timed_motor_run_overload_stop_top_defines.svh
// Assertion macros shared by the timed motor run sequencer RTL.
// Every user supplies clk and rst in scope; nothing else is needed.
`ifndef TIMED_MOTOR_RUN_OVERLOAD_STOP_TOP_DEFINES_SVH
`define TIMED_MOTOR_RUN_OVERLOAD_STOP_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TMROS_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TMROS_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/tmros_pkg.sv
// Package for the timed motor run sequencer: constants, codes and shared types.
// Used by every module of the block; depends on nothing.
package tmros_pkg;

  localparam int TIMER_BITS    = 16;
  localparam int LEARN_SAMPLES = 3;
  localparam int CNT_W         = $clog2(LEARN_SAMPLES + 1);
  localparam int PEAK_W        = 13;
  localparam int LEVEL_W       = 12;
  localparam int SENS_W        = 10;
  localparam int DUTY_W        = 12;
  localparam int MS_W          = 16;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;

  localparam logic [PEAK_W-1:0] PEAK_MAX = {PEAK_W{1'b1}};

  // Operation codes of an input beat.
  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_START_FWD = 2'd1;
  localparam logic [1:0] OP_START_REV = 2'd2;
  localparam logic [1:0] OP_STOP      = 2'd3;

  // Run direction codes; the start codes equal the directions they set.
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  // Phase codes.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_FAST  = 2'd2;
  localparam logic [1:0] PH_TAIL  = 2'd3;

  // Register indexes (word address).
  localparam logic [2:0] REG_RUN_TIME   = 3'd0;
  localparam logic [2:0] REG_SENS       = 3'd1;
  localparam logic [2:0] REG_LEG_SWAP   = 3'd2;
  localparam logic [2:0] REG_SLOW_DUTY  = 3'd3;
  localparam logic [2:0] REG_FAST_DUTY  = 3'd4;
  localparam logic [2:0] REG_FAST_UNTIL = 3'd5;
  localparam logic [2:0] REG_TAIL_FROM  = 3'd6;

  // Register reset values.
  localparam logic [MS_W-1:0]   RST_RUN_TIME   = 16'd6000;
  localparam logic [SENS_W-1:0] RST_SENS       = 10'd50;
  localparam logic              RST_LEG_SWAP   = 1'b0;
  localparam logic [DUTY_W-1:0] RST_SLOW_DUTY  = 12'd1000;
  localparam logic [DUTY_W-1:0] RST_FAST_DUTY  = 12'd4000;
  localparam logic [MS_W-1:0]   RST_FAST_UNTIL = 16'd4000;
  localparam logic [MS_W-1:0]   RST_TAIL_FROM  = 16'd2000;

  typedef struct packed {
    logic [MS_W-1:0]   run_time_ms;
    logic [SENS_W-1:0] sensitivity;
    logic              leg_swap;
    logic [DUTY_W-1:0] slow_duty;
    logic [DUTY_W-1:0] fast_duty;
    logic [MS_W-1:0]   fast_until_ms;
    logic [MS_W-1:0]   tail_from_ms;
  } cfg_t;

  typedef struct packed {
    logic              drive_a;
    logic              drive_b;
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [1:0]        phase;
    logic              overload;
    logic [MS_W-1:0]   time_left;
  } result_t;

endpackage

>>> src/tmros_cfg_regs.sv
// APB-style configuration register file of the timed motor run sequencer.
// Depends on tmros_pkg for register indexes, reset values and cfg_t.
module tmros_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tmros_pkg::ADDR_W-1:0]  paddr,
  input  logic [tmros_pkg::DATA_W-1:0]  pwdata,
  output logic [tmros_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output tmros_pkg::cfg_t               cfg
);
  import tmros_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.run_time_ms   <= RST_RUN_TIME;
      cfg.sensitivity   <= RST_SENS;
      cfg.leg_swap      <= RST_LEG_SWAP;
      cfg.slow_duty     <= RST_SLOW_DUTY;
      cfg.fast_duty     <= RST_FAST_DUTY;
      cfg.fast_until_ms <= RST_FAST_UNTIL;
      cfg.tail_from_ms  <= RST_TAIL_FROM;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RUN_TIME:   cfg.run_time_ms   <= pwdata[MS_W-1:0];
        REG_SENS:       cfg.sensitivity   <= pwdata[SENS_W-1:0];
        REG_LEG_SWAP:   cfg.leg_swap      <= pwdata[0];
        REG_SLOW_DUTY:  cfg.slow_duty     <= pwdata[DUTY_W-1:0];
        REG_FAST_DUTY:  cfg.fast_duty     <= pwdata[DUTY_W-1:0];
        REG_FAST_UNTIL: cfg.fast_until_ms <= pwdata[MS_W-1:0];
        REG_TAIL_FROM:  cfg.tail_from_ms  <= pwdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RUN_TIME:   prdata = DATA_W'(cfg.run_time_ms);
      REG_SENS:       prdata = DATA_W'(cfg.sensitivity);
      REG_LEG_SWAP:   prdata = DATA_W'(cfg.leg_swap);
      REG_SLOW_DUTY:  prdata = DATA_W'(cfg.slow_duty);
      REG_FAST_DUTY:  prdata = DATA_W'(cfg.fast_duty);
      REG_FAST_UNTIL: prdata = DATA_W'(cfg.fast_until_ms);
      REG_TAIL_FROM:  prdata = DATA_W'(cfg.tail_from_ms);
      default:        prdata = '0;
    endcase
  end

endmodule

>>> src/tmros_seq_core.sv
// Run state of the sequencer and the single-pass update for one beat.
// Depends on tmros_pkg and the assertion macros in the defines header.
`include "timed_motor_run_overload_stop_top_defines.svh"

module tmros_seq_core (
  input  logic                           clk,
  input  logic                           rst,
  input  tmros_pkg::cfg_t                cfg,
  input  logic                           fire,
  input  logic [1:0]                     op,
  input  logic [tmros_pkg::LEVEL_W-1:0]  load_level,
  output tmros_pkg::result_t             res
);
  import tmros_pkg::*;

  logic [TIMER_BITS-1:0] rem, rem_next, rem_dec;
  logic [1:0]            dir, dir_next;
  logic [1:0]            cur, cur_next;
  logic [1:0]            prev, prev_next;
  logic [PEAK_W-1:0]     peak, peak_next, base_peak, peak_sat;
  logic [CNT_W-1:0]      cnt, cnt_next, base_cnt, cnt_inc;
  logic [1:0]            pins, pins_next;
  logic [DUTY_W-1:0]     duty_a, duty_a_next, duty_b, duty_b_next, duty_sel;
  logic [1:0]            ph;
  logic                  hit;
  logic [PEAK_W:0]       level_sum;

  // Phase from the decremented timer, and detector base after a possible re-arm.
  always_comb begin
    rem_dec = (rem != '0) ? rem - 1'b1 : rem;
    if (32'(rem_dec) > 32'(cfg.fast_until_ms)) begin
      ph = PH_START;
    end else if (32'(rem_dec) > 32'(cfg.tail_from_ms)) begin
      ph = PH_FAST;
    end else begin
      ph = PH_TAIL;
    end
    base_peak = (ph != prev) ? '0 : peak;
    base_cnt  = (ph != prev) ? '0 : cnt;
    cnt_inc   = (base_cnt < CNT_W'(LEARN_SAMPLES)) ? base_cnt + 1'b1 : base_cnt;
    level_sum = (PEAK_W+1)'(load_level) + (PEAK_W+1)'(cfg.sensitivity);
    peak_sat  = (level_sum > (PEAK_W+1)'(PEAK_MAX)) ? PEAK_MAX : level_sum[PEAK_W-1:0];
    duty_sel  = (ph == PH_FAST) ? cfg.fast_duty : cfg.slow_duty;
  end

  always_comb begin
    rem_next    = rem;
    dir_next    = dir;
    cur_next    = cur;
    prev_next   = prev;
    peak_next   = peak;
    cnt_next    = cnt;
    pins_next   = pins;
    duty_a_next = duty_a;
    duty_b_next = duty_b;
    hit         = 1'b0;
    unique case (op)
      OP_START_FWD, OP_START_REV: begin
        rem_next = TIMER_BITS'(cfg.run_time_ms);
        dir_next = op;
      end
      OP_STOP: begin
        rem_next    = '0;
        pins_next   = '0;
        duty_a_next = '0;
        duty_b_next = '0;
      end
      OP_TICK: begin
        rem_next = rem_dec;
        if (rem_dec != '0) begin
          if (dir == DIR_FWD || dir == DIR_REV) begin
            cur_next  = ph;
            prev_next = ph;
            cnt_next  = cnt_inc;
            peak_next = base_peak;
            if (cnt_inc < CNT_W'(LEARN_SAMPLES)) begin
              if (PEAK_W'(load_level) > base_peak) begin
                peak_next = peak_sat;
              end
            end else begin
              hit = PEAK_W'(load_level) > base_peak;
            end
            if ((dir == DIR_FWD) == cfg.leg_swap) begin
              pins_next   = 2'b01;
              duty_a_next = duty_sel;
              duty_b_next = '0;
            end else begin
              pins_next   = 2'b10;
              duty_a_next = '0;
              duty_b_next = duty_sel;
            end
            if (hit) begin
              rem_next = '0;
            end
          end
        end else begin
          cur_next    = PH_IDLE;
          peak_next   = '0;
          cnt_next    = '0;
          pins_next   = '0;
          duty_a_next = '0;
          duty_b_next = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem    <= '0;
      dir    <= DIR_NONE;
      cur    <= PH_IDLE;
      prev   <= PH_IDLE;
      peak   <= '0;
      cnt    <= '0;
      pins   <= '0;
      duty_a <= '0;
      duty_b <= '0;
    end else if (fire) begin
      rem    <= rem_next;
      dir    <= dir_next;
      cur    <= cur_next;
      prev   <= prev_next;
      peak   <= peak_next;
      cnt    <= cnt_next;
      pins   <= pins_next;
      duty_a <= duty_a_next;
      duty_b <= duty_b_next;
    end
  end

  always_comb begin
    res.drive_a   = pins_next[0];
    res.drive_b   = pins_next[1];
    res.duty_a    = duty_a_next;
    res.duty_b    = duty_b_next;
    res.phase     = cur_next;
    res.overload  = hit;
    res.time_left = MS_W'(rem_next);
  end

  `TMROS_CHECK(a_legs_exclusive, 1'b1, !(pins[0] && pins[1]), "both bridge legs driven")
  `TMROS_CHECK(a_idle_bridge_off, cur == PH_IDLE, pins == '0 && duty_a == '0 && duty_b == '0,
    "bridge driven while idle")
  `TMROS_CHECK(a_trip_ends_run, fire && hit, res.time_left == '0, "overload left time on run")
  `TMROS_CHECK_NEXT(a_stop_clears, fire && op == OP_STOP, rem == '0 && pins == '0,
    "stop did not end the run")

endmodule

>>> src/timed_motor_run_overload_stop_top.sv
// Top level of the timed H-bridge run sequencer with overload cut-off.
// Depends on tmros_pkg, tmros_cfg_regs and tmros_seq_core.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------
//  in      | to block  | in_valid, in_stall | op, load_level
//  out     | from block| out_valid, out_stall| drive_a/b, duty_a/b, phase, overload,
//          |           |                    | time_left
//  cfg     | to block  | psel, penable      | paddr, pwdata, pwrite, prdata, pready
//
// Every beat passes through the input register, then through the state update
// into the result register.
// One beat is accepted per cycle as long as the result side keeps taking beats.
// A stall on the result side holds the result register and then the input
// register; in_stall rises only when both are full.
// Synchronous reset clears the run state and both valid flags; registers reset
// to their documented defaults.
module timed_motor_run_overload_stop_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic [tmros_pkg::LEVEL_W-1:0] load_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          drive_a,
  output logic                          drive_b,
  output logic [tmros_pkg::DUTY_W-1:0]  duty_a,
  output logic [tmros_pkg::DUTY_W-1:0]  duty_b,
  output logic [1:0]                    phase,
  output logic                          overload,
  output logic [tmros_pkg::MS_W-1:0]    time_left,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tmros_pkg::ADDR_W-1:0]  paddr,
  input  logic [tmros_pkg::DATA_W-1:0]  pwdata,
  output logic [tmros_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);
  import tmros_pkg::*;

  cfg_t               cfg;
  result_t            core_res;
  result_t            out_res;
  logic               s1_valid;
  logic [1:0]         s1_op;
  logic [LEVEL_W-1:0] s1_level;
  logic               adv_out;
  logic               fire;
  logic               in_accept;

  assign adv_out   = !out_valid || !out_stall;
  assign fire      = s1_valid && adv_out;
  assign in_stall  = s1_valid && !adv_out;
  assign in_accept = in_valid && !in_stall;

  tmros_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tmros_seq_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fire       (fire),
    .op         (s1_op),
    .load_level (s1_level),
    .res        (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op    <= op;
      s1_level <= load_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= core_res;
    end
  end

  assign drive_a   = out_res.drive_a;
  assign drive_b   = out_res.drive_b;
  assign duty_a    = out_res.duty_a;
  assign duty_b    = out_res.duty_b;
  assign phase     = out_res.phase;
  assign overload  = out_res.overload;
  assign time_left = out_res.time_left;

endmodule

>>> sim/run_sequence_checker.sv
// Checker for the timed motor run sequencer: watches the input, result and register ports,
// predicts every result beat from its own copy of the run state, and compares field by field.
// Depends on tmros_pkg only.
module run_sequence_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic [tmros_pkg::LEVEL_W-1:0] load_level,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          drive_a,
  input  logic                          drive_b,
  input  logic [tmros_pkg::DUTY_W-1:0]  duty_a,
  input  logic [tmros_pkg::DUTY_W-1:0]  duty_b,
  input  logic [1:0]                    phase,
  input  logic                          overload,
  input  logic [tmros_pkg::MS_W-1:0]    time_left,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [tmros_pkg::ADDR_W-1:0]  paddr,
  input  logic [tmros_pkg::DATA_W-1:0]  pwdata,
  output int                            failures,
  output int                            pending_beats
);
  import tmros_pkg::*;

  cfg_t              regs;
  logic [MS_W-1:0]   ms_left;
  logic [1:0]        run_dir;
  logic [1:0]        phase_now;
  logic [1:0]        phase_last;
  logic [PEAK_W-1:0] peak;
  logic [CNT_W-1:0]  samples;
  logic              tripped;
  logic              pin_a;
  logic              pin_b;
  logic [DUTY_W-1:0] leg_duty_a;
  logic [DUTY_W-1:0] leg_duty_b;

  result_t expected_results[$];
  result_t predicted;
  result_t oldest;
  int      bad_fields = 0;

  task step_run_sequencer(input logic [1:0] cmd, input logic [LEVEL_W-1:0] level,
                          output result_t r);
    logic [1:0]        ph;
    logic [DUTY_W-1:0] duty;
    int                sum;
    logic              hit;
    hit = 1'b0;
    case (cmd)
      OP_START_FWD, OP_START_REV: begin
        ms_left = regs.run_time_ms;
        run_dir = cmd;
        tripped = 1'b0;
      end
      OP_STOP: begin
        ms_left = '0;
        {pin_a, pin_b, leg_duty_a, leg_duty_b} = '0;
      end
      default: begin
        if (ms_left != '0) ms_left = ms_left - 1'b1;
        if (ms_left == '0) begin
          phase_now = PH_IDLE;
          tripped = 1'b0;
          peak = '0;
          samples = '0;
          {pin_a, pin_b, leg_duty_a, leg_duty_b} = '0;
        end else if (run_dir == DIR_FWD || run_dir == DIR_REV) begin
          if (ms_left > regs.fast_until_ms) ph = PH_START;
          else if (ms_left > regs.tail_from_ms) ph = PH_FAST;
          else ph = PH_TAIL;
          phase_now = ph;
          if (ph != phase_last) begin
            phase_last = ph;
            peak = '0;
            samples = '0;
          end
          if (samples < LEARN_SAMPLES) samples = samples + 1'b1;
          if (samples < LEARN_SAMPLES) begin
            if (level > peak) begin
              sum = int'(level) + int'(regs.sensitivity);
              peak = (sum > int'(PEAK_MAX)) ? PEAK_MAX : PEAK_W'(sum);
            end
          end else if (level > peak) begin
            tripped = 1'b1;
          end
          duty = (ph == PH_FAST) ? regs.fast_duty : regs.slow_duty;
          if ((run_dir == DIR_FWD) == regs.leg_swap) begin
            {pin_a, pin_b, leg_duty_a, leg_duty_b} = {1'b1, 1'b0, duty, {DUTY_W{1'b0}}};
          end else begin
            {pin_a, pin_b, leg_duty_a, leg_duty_b} = {1'b0, 1'b1, {DUTY_W{1'b0}}, duty};
          end
          if (tripped) begin
            hit = 1'b1;
            ms_left = '0;
          end
        end
      end
    endcase
    r.drive_a   = pin_a;
    r.drive_b   = pin_b;
    r.duty_a    = leg_duty_a;
    r.duty_b    = leg_duty_b;
    r.phase     = phase_now;
    r.overload  = hit;
    r.time_left = ms_left;
  endtask

  task check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      // Reporting is capped so that a broken block cannot flood the log.
      if (bad_fields < 100) $error("%s: expected %0d, got %0d", name, want, got);
      bad_fields++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs.run_time_ms   = RST_RUN_TIME;
      regs.sensitivity   = RST_SENS;
      regs.leg_swap      = RST_LEG_SWAP;
      regs.slow_duty     = RST_SLOW_DUTY;
      regs.fast_duty     = RST_FAST_DUTY;
      regs.fast_until_ms = RST_FAST_UNTIL;
      regs.tail_from_ms  = RST_TAIL_FROM;
      ms_left    = '0;
      run_dir    = DIR_NONE;
      phase_now  = PH_IDLE;
      phase_last = PH_IDLE;
      peak       = '0;
      samples    = '0;
      tripped    = 1'b0;
      {pin_a, pin_b, leg_duty_a, leg_duty_b} = '0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat arrived with no result expected");
          bad_fields++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("drive_a", 32'(oldest.drive_a), 32'(drive_a));
          check_field("drive_b", 32'(oldest.drive_b), 32'(drive_b));
          check_field("duty_a", 32'(oldest.duty_a), 32'(duty_a));
          check_field("duty_b", 32'(oldest.duty_b), 32'(duty_b));
          check_field("phase", 32'(oldest.phase), 32'(phase));
          check_field("overload", 32'(oldest.overload), 32'(overload));
          check_field("time_left", 32'(oldest.time_left), 32'(time_left));
        end
      end
      if (in_valid && !in_stall) begin
        step_run_sequencer(op, load_level, predicted);
        expected_results.push_back(predicted);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_RUN_TIME:   regs.run_time_ms   = pwdata[MS_W-1:0];
          REG_SENS:       regs.sensitivity   = pwdata[SENS_W-1:0];
          REG_LEG_SWAP:   regs.leg_swap      = pwdata[0];
          REG_SLOW_DUTY:  regs.slow_duty     = pwdata[DUTY_W-1:0];
          REG_FAST_DUTY:  regs.fast_duty     = pwdata[DUTY_W-1:0];
          REG_FAST_UNTIL: regs.fast_until_ms = pwdata[MS_W-1:0];
          REG_TAIL_FROM:  regs.tail_from_ms  = pwdata[MS_W-1:0];
          default: ;
        endcase
      end
    end
    failures      <= bad_fields;
    pending_beats <= expected_results.size();
  end

endmodule

>>> sim/tb.sv
// Testbench top for the timed motor run sequencer: clock, reset, register setup, directed
// and random run sequences with bursty input and a stalling receiver, and the verdict.
// Depends on tmros_pkg, timed_motor_run_overload_stop_top and run_sequence_checker.
module tb;
  import tmros_pkg::*;

  localparam int HANG_LIMIT = 3000;
  localparam int RANDOM_BEATS = 800;
  localparam int DIRECTED_BEATS = 25;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         op = OP_TICK;
  logic [LEVEL_W-1:0] load_level = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               drive_a;
  logic               drive_b;
  logic [DUTY_W-1:0]  duty_a;
  logic [DUTY_W-1:0]  duty_b;
  logic [1:0]         phase;
  logic               overload;
  logic [MS_W-1:0]    time_left;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int failures;
  int pending_beats;
  int beats_sent = 0;
  int burst_left = 0;
  int quiet_cycles = 0;
  int stall_mode = 0;
  int mode_left = 0;

  timed_motor_run_overload_stop_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .load_level(load_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .drive_a(drive_a), .drive_b(drive_b), .duty_a(duty_a), .duty_b(duty_b),
    .phase(phase), .overload(overload), .time_left(time_left),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  run_sequence_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .load_level(load_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .drive_a(drive_a), .drive_b(drive_b), .duty_a(duty_a), .duty_b(duty_b),
    .phase(phase), .overload(overload), .time_left(time_left),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .failures(failures), .pending_beats(pending_beats)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(20, 150);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task send_beat(input logic [1:0] cmd, input logic [LEVEL_W-1:0] level);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    op <= cmd;
    load_level <= level;
    do @(posedge clk); while (in_stall);
    burst_left--;
    beats_sent++;
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_beats != 0);
    repeat (4) @(posedge clk);
  endtask

  task reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task apply_settings(input logic [MS_W-1:0] run_ms, input logic [SENS_W-1:0] sens,
                      input logic swap, input logic [DUTY_W-1:0] slow,
                      input logic [DUTY_W-1:0] fast, input logic [MS_W-1:0] fast_until,
                      input logic [MS_W-1:0] tail_from);
    reg_write(REG_RUN_TIME, DATA_W'(run_ms));
    reg_write(REG_SENS, DATA_W'(sens));
    reg_write(REG_LEG_SWAP, DATA_W'(swap));
    reg_write(REG_SLOW_DUTY, DATA_W'(slow));
    reg_write(REG_FAST_DUTY, DATA_W'(fast));
    reg_write(REG_FAST_UNTIL, DATA_W'(fast_until));
    reg_write(REG_TAIL_FROM, DATA_W'(tail_from));
  endtask

  initial begin
    logic [MS_W-1:0]   s_run;
    logic [MS_W-1:0]   s_fu;
    logic [MS_W-1:0]   s_tf;
    logic [SENS_W-1:0] s_sens;
    logic              s_swap;
    logic [DUTY_W-1:0] s_slow;
    logic [DUTY_W-1:0] s_fast;
    int                round;
    int                round_end;
    int                base;
    int                jit;
    int                ticks;
    int                roll;
    int                lv;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Idle ticks, a run tripped by overload on its first compared sample,
    // a reverse run that learns a high baseline, then a stop.
    send_beat(OP_TICK, 12'd0);
    send_beat(OP_TICK, 12'd4095);
    send_beat(OP_START_FWD, 12'd0);
    send_beat(OP_TICK, 12'd0);
    send_beat(OP_TICK, 12'd0);
    send_beat(OP_TICK, 12'd1);
    send_beat(OP_TICK, 12'd4095);
    send_beat(OP_START_REV, 12'd4095);
    send_beat(OP_TICK, 12'd100);
    send_beat(OP_TICK, 12'd4095);
    send_beat(OP_TICK, 12'd4095);
    send_beat(OP_STOP, 12'd0);
    send_beat(OP_TICK, 12'd0);
    wait_drained();

    // A short run that walks through start, fast and tail phases to the end.
    apply_settings(16'd8, 10'd0, 1'b1, 12'd4095, 12'd1, 16'd5, 16'd2);
    send_beat(OP_START_FWD, 12'd2000);
    repeat (8) send_beat(OP_TICK, 12'd2000);
    send_beat(OP_START_REV, 12'd0);
    send_beat(OP_TICK, 12'd0);
    send_beat(OP_STOP, 12'd4095);

    round = 0;
    while (beats_sent < DIRECTED_BEATS + RANDOM_BEATS) begin
      wait_drained();
      s_sens = SENS_W'($urandom_range(0, 1023));
      s_swap = 1'($urandom_range(0, 1));
      s_slow = DUTY_W'($urandom_range(0, 4095));
      s_fast = DUTY_W'($urandom_range(0, 4095));
      case (round % 5)
        0: begin
          s_run = MS_W'($urandom_range(10, 60));
          s_fu = MS_W'($urandom_range(0, s_run));
          s_tf = MS_W'($urandom_range(0, s_fu));
        end
        1: begin
          {s_run, s_sens, s_swap, s_slow, s_fast} = {16'd65535, 10'd1023, 1'b1, 12'd4095, 12'd4095};
          s_fu = 16'd65530;
          s_tf = 16'd65520;
        end
        2: begin
          {s_run, s_sens, s_swap, s_slow, s_fast, s_fu, s_tf} = '0;
        end
        3: begin
          s_run = MS_W'($urandom_range(10, 50));
          s_fu = MS_W'($urandom_range(0, 20));
          s_tf = MS_W'($urandom_range(65535, s_fu));
        end
        default: begin
          s_run = MS_W'($urandom_range(0, 65535));
          s_fu = MS_W'($urandom_range(0, 65535));
          s_tf = MS_W'($urandom_range(0, 65535));
        end
      endcase
      apply_settings(s_run, s_sens, s_swap, s_slow, s_fast, s_fu, s_tf);
      round_end = beats_sent + ((round % 5 == 2) ? 30 : $urandom_range(80, 140));
      while (beats_sent < round_end) begin
        if ($urandom_range(0, 7) == 0) begin
          send_beat(2'($urandom_range(0, 3)), LEVEL_W'($urandom_range(0, 4095)));
        end else begin
          send_beat($urandom_range(0, 1) ? OP_START_REV : OP_START_FWD,
                    LEVEL_W'($urandom_range(0, 4095)));
          base = $urandom_range(0, 4095);
          jit = $urandom_range(0, 64);
          ticks = $urandom_range(1, 40);
          repeat (ticks) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
              send_beat(OP_STOP, LEVEL_W'($urandom_range(0, 4095)));
            end else if (roll < 6) begin
              send_beat(2'($urandom_range(0, 3)), LEVEL_W'($urandom_range(0, 4095)));
            end else if (roll < 10) begin
              send_beat(OP_TICK, LEVEL_W'($urandom_range(0, 4095)));
            end else begin
              lv = base - jit + int'($urandom_range(0, 2 * jit));
              if (lv < 0) lv = 0;
              if (lv > 4095) lv = 4095;
              send_beat(OP_TICK, LEVEL_W'(lv));
            end
          end
        end
      end
      round++;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

>>> timed_motor_run_overload_stop_top.f
+incdir+src
src/tmros_pkg.sv
src/tmros_cfg_regs.sv
src/tmros_seq_core.sv
src/timed_motor_run_overload_stop_top.sv
sim/run_sequence_checker.sv
sim/tb.sv
